// ----- hdl/gtef_pkg.sv -----
// Shared constants and types for the grid threshold edge finder.
`default_nettype none

package gtef_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int VALUE_W    = 16;
   localparam int COORD_W    = 11;
   localparam int MODE_W     = 2;
   localparam int SIDE_W     = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [VALUE_W-1:0] CONC_THR_RESET = VALUE_W'(1500);
   localparam logic [VALUE_W-1:0] DIST_THR_RESET = '0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CONC_THR  = 2'd0,
      CSR_DIST_THR  = 2'd1,
      CSR_MASK_MODE = 2'd2
   } csr_index_type;

   localparam logic [MODE_W-1:0] MASK_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MASK_LAND  = 2'd1;
   localparam logic [MODE_W-1:0] MASK_COAST = 2'd2;

   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_UP    = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_DOWN  = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] conc;
      logic               land;
      logic [VALUE_W-1:0] coast;
   } cell_type;

endpackage

`default_nettype wire

// ----- hdl/gtef_ifs.sv -----
// Valid/ready channel interfaces for grid cells and edge results.
`default_nettype none

interface gtef_req_if
   import gtef_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] conc_value;
   logic               land_flag;
   logic [VALUE_W-1:0] coast_distance;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, conc_value, land_flag, coast_distance, row_end, frame_end,
                   input ready);
   modport sink (input valid, conc_value, land_flag, coast_distance, row_end, frame_end,
                 output ready);
endinterface

interface gtef_rsp_if
   import gtef_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] mid_x2;
   logic [COORD_W-1:0] mid_y2;
   logic [SIDE_W-1:0]  open_side;
   logic               last_of_run;

   modport source (output valid, mid_x2, mid_y2, open_side, last_of_run, input ready);
   modport sink (input valid, mid_x2, mid_y2, open_side, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/gtef_ram.sv -----
// Generic simple dual-port RAM, registered read, read-first on address collision.
`default_nettype none

module gtef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/grid_threshold_edge_finder.sv -----
// An accepted cell is registered in the compare stage; its edge results are then registered in the rsp register.
// Throughput: one cell per cycle while rsp is not stalled; a cell with both a left and an upper
//   edge stays in the compare stage until both results leave through the one rsp register.
// The line buffer is one RAM read and written at the same column each beat (read-first).
// Reset (synchronous): clears counters, previous cell, pipeline and output valid, and
//   loads register defaults; the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module grid_threshold_edge_finder
   import gtef_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gtef_req_if.sink              req_chan,
   gtef_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int XW    = (COL_W + 1 > COORD_W) ? COL_W + 1 : COORD_W;
   localparam int YW    = (ROW_W + 1 > COORD_W) ? ROW_W + 1 : COORD_W;
   localparam int CELL_W = $bits(cell_type);

   function automatic logic pair_hit(cell_type a, cell_type b,
                                     logic [VALUE_W-1:0] thr,
                                     logic [VALUE_W-1:0] dthr,
                                     logic [MODE_W-1:0] mode);
      logic               a_ice;
      logic               b_ice;
      logic [VALUE_W-1:0] ice_dist;
      logic               ok;
      a_ice    = a.conc >= thr;
      b_ice    = b.conc >= thr;
      ice_dist = a_ice ? a.coast : b.coast;
      case (mode)
         MASK_LAND:  ok = !a.land && !b.land;
         MASK_COAST: ok = ice_dist > dthr;
         default:    ok = 1'b1;
      endcase
      return (a_ice != b_ice) && ok;
   endfunction

   // configuration registers
   logic [VALUE_W-1:0] conc_thr_ff;
   logic [VALUE_W-1:0] dist_thr_ff;
   logic [MODE_W-1:0]  mask_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conc_thr_ff  <= CONC_THR_RESET;
         dist_thr_ff  <= DIST_THR_RESET;
         mask_mode_ff <= MASK_NONE;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CONC_THR:  conc_thr_ff  <= csr_wr_data[VALUE_W-1:0];
            CSR_DIST_THR:  dist_thr_ff  <= csr_wr_data[VALUE_W-1:0];
            CSR_MASK_MODE: mask_mode_ff <= csr_wr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage: raster position and line buffer access
   logic             req_fire;
   cell_type         cur_cell;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] prc_ff, prc_in;   // cells in previous row
   cell_type         prev_cell_ff;
   logic             col_last;
   logic             row_last;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign cur_cell = '{conc: req_chan.conc_value, land: req_chan.land_flag,
                       coast: req_chan.coast_distance};
   assign col_last = col_ff == COL_W'(MAX_WIDTH - 1);
   assign row_last = row_ff == ROW_W'(MAX_HEIGHT - 1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      prc_in = prc_ff;
      if (req_fire) begin
         if (req_chan.frame_end) begin
            col_in = '0;
            row_in = '0;
            prc_in = '0;
         end else if (req_chan.row_end || col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
               prc_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               prc_in = CNT_W'(col_ff) + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         prc_ff       <= '0;
         prev_cell_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         prc_ff <= prc_in;
         if (req_fire) begin
            prev_cell_ff <= cur_cell;
         end
      end
   end

   logic [CELL_W-1:0] up_raw;
   cell_type          up_cell;

   gtef_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (cur_cell),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (up_raw)
   );

   assign up_cell = cell_type'(up_raw);

   // compare stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_sent_left_ff, s1_sent_left_in;
   cell_type         s1_cur_ff;
   cell_type         s1_left_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_has_left_ff;
   logic             s1_has_up_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x2_ff;
   logic [COORD_W-1:0] rsp_y2_ff;
   logic [SIDE_W-1:0]  rsp_side_ff;
   logic               rsp_last_ff;

   logic left_hit;
   logic up_hit;
   logic left_pend;
   logic any_pend;
   logic out_free;
   logic emit;
   logic s1_retire;
   logic cur_ice;

   assign left_hit  = s1_has_left_ff &&
                      pair_hit(s1_left_ff, s1_cur_ff, conc_thr_ff, dist_thr_ff, mask_mode_ff);
   assign up_hit    = s1_has_up_ff &&
                      pair_hit(up_cell, s1_cur_ff, conc_thr_ff, dist_thr_ff, mask_mode_ff);
   assign left_pend = left_hit && !s1_sent_left_ff;
   assign any_pend  = left_pend || up_hit;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = s1_valid_ff && out_free && any_pend;
   // retire when nothing to send or the final result goes out now
   assign s1_retire = s1_valid_ff && (!any_pend || (out_free && !(left_pend && up_hit)));
   assign cur_ice   = s1_cur_ff.conc >= conc_thr_ff;

   assign req_chan.ready = !reset && (!s1_valid_ff || s1_retire);

   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_sent_left_in = s1_sent_left_ff;
      if (req_fire) begin
         s1_valid_in     = 1'b1;
         s1_sent_left_in = 1'b0;
      end else if (s1_retire) begin
         s1_valid_in = 1'b0;
      end else if (emit) begin
         s1_sent_left_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s1_sent_left_ff <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s1_sent_left_ff <= s1_sent_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cur_ff      <= cur_cell;
         s1_left_ff     <= prev_cell_ff;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_has_left_ff <= col_ff != '0;
         s1_has_up_ff   <= (row_ff != '0) && (CNT_W'(col_ff) < prc_ff);
      end
   end

   // result formatting: left pair first, then upper pair
   logic [XW-1:0]      col2;
   logic [YW-1:0]      row2;
   logic               sel_up;
   logic [COORD_W-1:0] x2_next;
   logic [COORD_W-1:0] y2_next;
   logic [SIDE_W-1:0]  side_next;

   assign col2   = XW'(s1_col_ff) << 1;
   assign row2   = YW'(s1_row_ff) << 1;
   assign sel_up = !left_pend;

   always_comb begin
      if (sel_up) begin
         x2_next   = COORD_W'(col2);
         y2_next   = COORD_W'(row2 - YW'(1));
         side_next = cur_ice ? SIDE_UP : SIDE_DOWN;
      end else begin
         x2_next   = COORD_W'(col2 - XW'(1));
         y2_next   = COORD_W'(row2);
         side_next = cur_ice ? SIDE_LEFT : SIDE_RIGHT;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x2_ff   <= x2_next;
         rsp_y2_ff   <= y2_next;
         rsp_side_ff <= side_next;
         rsp_last_ff <= sel_up || !up_hit;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mid_x2      = rsp_x2_ff;
   assign rsp_chan.mid_y2      = rsp_y2_ff;
   assign rsp_chan.open_side   = rsp_side_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/gtef_checker.sv -----
// Port-level assertions for the grid threshold edge finder, bound to the top level.
`default_nettype none

module gtef_checker
   import gtef_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] mid_x2,
   input logic [COORD_W-1:0] mid_y2,
   input logic [SIDE_W-1:0]  open_side,
   input logic               last_of_run
);

   logic horiz;
   assign horiz = (open_side == SIDE_LEFT) || (open_side == SIDE_RIGHT);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mid_x2) && $stable(mid_y2)
                                  && $stable(open_side) && $stable(last_of_run))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // horizontal pairs sit on an odd column and even row, vertical the other way
   a_horiz_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && horiz |-> mid_x2[0] && !mid_y2[0])
      else $error("horizontal edge midpoint parity");

   a_vert_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !horiz |-> !mid_x2[0] && mid_y2[0])
      else $error("vertical edge midpoint parity");

   // only a left pair can be followed by another result of the same cell
   a_first_is_horiz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |-> horiz)
      else $error("non-final beat is not a horizontal edge");

endmodule

bind grid_threshold_edge_finder gtef_checker u_gtef_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .mid_x2      (rsp_chan.mid_x2),
   .mid_y2      (rsp_chan.mid_y2),
   .open_side   (rsp_chan.open_side),
   .last_of_run (rsp_chan.last_of_run)
);

`default_nettype wire

// ----- sim/gtef_edge_checker.sv -----
// Edge predictor and result checker for the grid threshold edge finder.
module gtef_edge_checker
   import gtef_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gtef_req_if                   req_mon,
   gtef_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    pending_count,
   output int                    error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
      logic [SIDE_W-1:0]  side;
      logic               last;
   } edge_beat_type;

   edge_beat_type      pending_edges[$];
   logic [VALUE_W-1:0] conc_thr;
   logic [VALUE_W-1:0] dist_thr;
   logic [MODE_W-1:0]  mask_mode;
   cell_type           row_cells[MAX_WIDTH];
   cell_type           prev_cell;
   int                 col_cnt;
   int                 row_cnt;
   int                 upper_row_len;
   int                 errors = 0;

   // a is the left or upper neighbor, b the incoming cell
   function automatic bit pair_gives_edge(input cell_type a, input cell_type b,
                                          input bit vertical, input int col, input int row,
                                          output edge_beat_type e);
      bit       a_ice;
      bit       b_ice;
      cell_type ice;
      e = '0;
      a_ice = (a.conc >= conc_thr);
      b_ice = (b.conc >= conc_thr);
      if (a_ice == b_ice) return 1'b0;
      ice = a_ice ? a : b;
      if (mask_mode == MASK_LAND && (a.land || b.land)) return 1'b0;
      if (mask_mode == MASK_COAST && !(ice.coast > dist_thr)) return 1'b0;
      if (vertical) begin
         e.x2   = COORD_W'(2 * col);
         e.y2   = COORD_W'(2 * row - 1);
         e.side = b_ice ? SIDE_UP : SIDE_DOWN;
      end else begin
         e.x2   = COORD_W'(2 * col - 1);
         e.y2   = COORD_W'(2 * row);
         e.side = b_ice ? SIDE_LEFT : SIDE_RIGHT;
      end
      return 1'b1;
   endfunction

   task automatic predict_cell_edges(input cell_type cur, input bit re, input bit fe);
      edge_beat_type e;
      edge_beat_type found[$];
      int            col;
      int            row;
      col = col_cnt;
      row = row_cnt;
      if (col > 0 && pair_gives_edge(prev_cell, cur, 1'b0, col, row, e)) found.push_back(e);
      // upper pair only where the previous row reached this column
      if (row > 0 && col < upper_row_len &&
          pair_gives_edge(row_cells[col], cur, 1'b1, col, row, e)) found.push_back(e);
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending_edges.push_back(found[i]);
      row_cells[col] = cur;
      prev_cell = cur;
      if (fe) begin
         col_cnt = 0;
         row_cnt = 0;
         upper_row_len = 0;
      end else if (re || col == MAX_WIDTH - 1) begin
         col_cnt = 0;
         if (row + 1 >= MAX_HEIGHT) begin
            row_cnt = 0;
            upper_row_len = 0;
         end else begin
            row_cnt = row + 1;
            upper_row_len = col + 1;
         end
      end else begin
         col_cnt = col + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      cell_type      in_cell;
      edge_beat_type got;
      edge_beat_type want;
      if (reset) begin
         conc_thr = CONC_THR_RESET;
         dist_thr = DIST_THR_RESET;
         mask_mode = MASK_NONE;
         prev_cell = '0;
         col_cnt = 0;
         row_cnt = 0;
         upper_row_len = 0;
         pending_edges.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CONC_THR:  conc_thr = csr_wr_data[VALUE_W-1:0];
               CSR_DIST_THR:  dist_thr = csr_wr_data[VALUE_W-1:0];
               CSR_MASK_MODE: mask_mode = csr_wr_data[MODE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            in_cell.conc  = req_mon.conc_value;
            in_cell.land  = req_mon.land_flag;
            in_cell.coast = req_mon.coast_distance;
            predict_cell_edges(in_cell, req_mon.row_end, req_mon.frame_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.x2   = rsp_mon.mid_x2;
            got.y2   = rsp_mon.mid_y2;
            got.side = rsp_mon.open_side;
            got.last = rsp_mon.last_of_run;
            if (pending_edges.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected edge beat x2=%0d y2=%0d side=%0d last=%0d",
                           $realtime, got.x2, got.y2, got.side, got.last);
            end else begin
               want = pending_edges.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: edge beat differs: exp x2=%0d y2=%0d side=%0d last=%0d,",
                               " got x2=%0d y2=%0d side=%0d last=%0d"}, $realtime,
                              want.x2, want.y2, want.side, want.last,
                              got.x2, got.y2, got.side, got.last);
               end
            end
         end
      end
      pending_count <= pending_edges.size();
      error_count   <= errors;
   end

endmodule

// ----- sim/grid_threshold_edge_finder_tb.sv -----
// Top-level testbench: clock, reset, cell stimulus, result back-pressure and verdict.
module grid_threshold_edge_finder_tb
   import gtef_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MASK_SPARE      = 2'd3;
   localparam int                RSP_HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    pending_edge_count;
   int                    edge_errors;

   logic [VALUE_W-1:0]    cur_conc_thr;
   logic [VALUE_W-1:0]    cur_dist_thr;
   bit                    gaps_on;
   int                    burst_left;
   bit                    rsp_hold_request;

   gtef_req_if cell_chan ();
   gtef_rsp_if edge_chan ();

   grid_threshold_edge_finder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (cell_chan),
      .rsp_chan    (edge_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   gtef_edge_checker edge_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (cell_chan),
      .rsp_mon       (edge_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .pending_count (pending_edge_count),
      .error_count   (edge_errors)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #10_000_000;
      $display("grid_threshold_edge_finder: mismatch");
      $finish;
   end

   // result side back-pressure, with one long hold on request
   initial begin : rsp_stall
      int mode;
      int stretch;
      edge_chan.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(10, 150);
         repeat (stretch) begin
            @(posedge clock);
            if (rsp_hold_request) begin
               edge_chan.ready <= 1'b0;
               repeat (RSP_HOLD_CYCLES) @(posedge clock);
               rsp_hold_request = 1'b0;
            end
            case (mode)
               0:       edge_chan.ready <= 1'b1;
               1:       edge_chan.ready <= 1'($urandom_range(0, 1));
               2:       edge_chan.ready <= ($urandom_range(0, 5) == 0);
               default: edge_chan.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   function automatic logic [VALUE_W-1:0] pick_near(input logic [VALUE_W-1:0] center);
      int v;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return VALUE_W'($urandom);
         default: begin
            v = int'(center) + int'($urandom_range(0, 9)) - 5;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return VALUE_W'(v);
         end
      endcase
   endfunction

   task automatic send_cell(input logic [VALUE_W-1:0] conc, input logic land,
                            input logic [VALUE_W-1:0] coast, input logic re, input logic fe);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            cell_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      cell_chan.valid          <= 1'b1;
      cell_chan.conc_value     <= conc;
      cell_chan.land_flag      <= land;
      cell_chan.coast_distance <= coast;
      cell_chan.row_end        <= re;
      cell_chan.frame_end      <= fe;
      do @(posedge clock); while (!cell_chan.ready);
   endtask

   task automatic send_random_cell(input logic re, input logic fe);
      send_cell(pick_near(cur_conc_thr), ($urandom_range(0, 3) == 0),
                pick_near(cur_dist_thr), re, fe);
   endtask

   // stop offering cells and wait until every predicted edge has come back
   task automatic drain();
      cell_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_edge_count != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_config(input logic [VALUE_W-1:0] thr, input logic [VALUE_W-1:0] dthr,
                             input logic [MODE_W-1:0] mode);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CONC_THR;
      csr_wr_data <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index   <= CSR_DIST_THR;
      csr_wr_data <= CSR_DATA_W'(dthr);
      @(posedge clock);
      csr_index   <= CSR_MASK_MODE;
      csr_wr_data <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_conc_thr = thr;
      cur_dist_thr = dthr;
   endtask

   // random grids: mostly regular rows, some ragged, optional stray flags
   task automatic run_grids(input int n_cells, input bit noisy, input bit pauses);
      int sent;
      int width;
      int rows;
      int w;
      bit re;
      bit fe;
      sent = 0;
      while (sent < n_cells) begin
         width = $urandom_range(1, 16);
         rows = $urandom_range(1, 8);
         for (int r = 0; r < rows; r++) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : width;
            for (int c = 0; c < w; c++) begin
               re = (c == w - 1);
               fe = re && (r == rows - 1);
               if (fe && $urandom_range(0, 3) == 0) re = 1'b0;
               if (noisy && $urandom_range(0, 7) == 0) begin
                  re = 1'($urandom_range(0, 1));
                  fe = ($urandom_range(0, 3) == 0);
               end
               send_random_cell(re, fe);
               sent++;
            end
         end
         if (pauses && $urandom_range(0, 4) == 0) drain();
      end
   endtask

   initial begin
      cell_chan.valid          <= 1'b0;
      cell_chan.conc_value     <= '0;
      cell_chan.land_flag      <= 1'b0;
      cell_chan.coast_distance <= '0;
      cell_chan.row_end        <= 1'b0;
      cell_chan.frame_end      <= 1'b0;
      csr_wr_en                <= 1'b0;
      csr_index                <= CSR_CONC_THR;
      csr_wr_data              <= '0;
      reset                    <= 1'b1;
      gaps_on = 1'b1;
      burst_left = 0;
      rsp_hold_request = 1'b0;
      cur_conc_thr = CONC_THR_RESET;
      cur_dist_thr = DIST_THR_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed grid at reset settings: all four sides, threshold boundary,
      // ragged rows, frame end without row end
      send_cell(16'd0,     1'b0, 16'd0,     1'b0, 1'b0);
      send_cell(16'hFFFF,  1'b1, 16'hFFFF,  1'b0, 1'b0);
      send_cell(16'd1499,  1'b0, 16'd1,     1'b0, 1'b0);
      send_cell(16'd1500,  1'b1, 16'hFFFE,  1'b1, 1'b0);
      send_cell(16'hFFFF,  1'b0, 16'd0,     1'b0, 1'b0);
      send_cell(16'd0,     1'b0, 16'hFFFF,  1'b0, 1'b0);
      send_cell(16'd1500,  1'b1, 16'd7,     1'b0, 1'b0);
      send_cell(16'd1500,  1'b0, 16'd1500,  1'b1, 1'b0);
      send_cell(16'd0,     1'b1, 16'd0,     1'b0, 1'b0);
      send_cell(16'd0,     1'b0, 16'd3,     1'b0, 1'b0);
      send_cell(16'd0,     1'b1, 16'd0,     1'b0, 1'b0);
      send_cell(16'd0,     1'b0, 16'hFFFF,  1'b0, 1'b0);
      send_cell(16'hFFFF,  1'b1, 16'hFFFF,  1'b1, 1'b0);
      send_cell(16'hFFFF,  1'b0, 16'd0,     1'b0, 1'b1);
      send_cell(16'd0,     1'b0, 16'd0,     1'b0, 1'b0);
      send_cell(16'd1500,  1'b1, 16'hFFFF,  1'b1, 1'b1);

      set_config(16'd20000, 16'd0, MASK_LAND);
      run_grids(60, 1'b0, 1'b1);
      set_config(16'd20000, 16'd1000, MASK_COAST);
      run_grids(60, 1'b0, 1'b1);

      // long result hold while cells keep coming, then a full pause
      set_config(CONC_THR_RESET, DIST_THR_RESET, MASK_NONE);
      gaps_on = 1'b0;
      rsp_hold_request = 1'b1;
      run_grids(80, 1'b0, 1'b0);
      drain();
      run_grids(30, 1'b0, 1'b0);

      set_config(16'd0, 16'hFFFF, MASK_SPARE);
      gaps_on = 1'b1;
      run_grids(60, 1'b1, 1'b1);
      set_config(16'hFFFF, 16'hFFFF, MASK_COAST);
      run_grids(50, 1'b0, 1'b1);
      set_config(16'hFFFF, 16'd0, MASK_NONE);
      run_grids(50, 1'b1, 1'b0);
      set_config(VALUE_W'($urandom), VALUE_W'($urandom), MASK_COAST);
      run_grids(80, 1'b1, 1'b1);
      set_config(VALUE_W'($urandom), 16'd0, MASK_LAND);
      gaps_on = 1'b0;
      run_grids(80, 1'b0, 1'b1);

      // one row past the line buffer width wraps to the next row
      set_config(16'd30000, 16'd0, MASK_NONE);
      gaps_on = 1'b1;
      for (int i = 0; i < 1030; i++) send_random_cell(1'b0, 1'b0);
      send_random_cell(1'b1, 1'b1);

      drain();
      repeat (10) @(posedge clock);
      if (edge_errors == 0 && pending_edge_count == 0) begin
         $display("grid_threshold_edge_finder: match");
      end else begin
         $display("grid_threshold_edge_finder: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/gtef_pkg.sv
hdl/gtef_ifs.sv
hdl/gtef_ram.sv
hdl/grid_threshold_edge_finder.sv
hdl/gtef_checker.sv
sim/gtef_edge_checker.sv
sim/grid_threshold_edge_finder_tb.sv
